[sv/lfp_pkg.sv]
`default_nettype none

package lfp_pkg;

    localparam int PPF_W   = 23;
    localparam int N_W     = 25;
    localparam int PIX_W   = 8;
    localparam int SQ_W    = 16;
    localparam int SSE_W   = 38;
    localparam int IDX_W   = 16;
    localparam int PSNR_W  = 15;
    localparam int X_W     = 41;
    localparam int E_W     = 6;
    localparam int FRAC_W  = 24;
    localparam int BIT_W   = 5;
    localparam int L_W     = E_W + FRAC_W;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SCALE_W = 26;

    localparam logic [PPF_W-1:0]   PPF_RESET       = 23'd101376;
    localparam logic [SQ_W-1:0]    LUMA_PEAK_SQ    = 16'd65025;
    // 10*log10(2) in Q.24
    localparam logic [SCALE_W-1:0] TEN_LOG10_2_Q24 = 26'd50504453;
    localparam logic [PSNR_W-1:0]  PSNR_MAX        = 15'd32767;
    localparam logic [PROD_W-1:0]  ROUND_HALF      = 64'h0000_0080_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULP,
        ST_LOADP,
        ST_NORM,
        ST_SQ_START,
        ST_SQ_RUN,
        ST_SCALE,
        ST_ROUND,
        ST_HOLD
    } lfp_state_t;

    typedef struct packed {
        logic             done;
        logic [SSE_W-1:0] sse;
        logic [N_W-1:0]   n;
        logic [IDX_W-1:0] index;
    } lfp_frame_t;

endpackage

`default_nettype wire

[sv/lfp_mul.sv]
`default_nettype none

module lfp_mul (
    input  wire logic                       clk,
    input  wire logic [lfp_pkg::MUL_W-1:0]  a,
    input  wire logic [lfp_pkg::MUL_W-1:0]  b,
    output logic      [lfp_pkg::PROD_W-1:0] p
);

    logic [lfp_pkg::PROD_W-1:0] p_reg;
    logic [lfp_pkg::PROD_W-1:0] p_next;

    assign p_next = lfp_pkg::PROD_W'(a) * lfp_pkg::PROD_W'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

[sv/lfp_accum.sv]
`default_nettype none

module lfp_accum #(
    parameter int MAX_PIXELS = 4194304
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       take,
    input  wire logic [lfp_pkg::PIX_W-1:0]  pixel_a,
    input  wire logic [lfp_pkg::PIX_W-1:0]  pixel_b,
    input  wire logic [lfp_pkg::PPF_W-1:0]  ppf,
    output lfp_pkg::lfp_frame_t             frm
);

    localparam int POS_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam logic [lfp_pkg::N_W-1:0] MAX_N = lfp_pkg::N_W'(MAX_PIXELS);

    logic [lfp_pkg::SSE_W-1:0] acc_reg;
    logic [lfp_pkg::SSE_W-1:0] acc_next;
    logic [POS_W-1:0]          pos_reg;
    logic [POS_W-1:0]          pos_next;
    logic [lfp_pkg::IDX_W-1:0] cnt_reg;
    logic [lfp_pkg::IDX_W-1:0] cnt_next;

    logic [lfp_pkg::PIX_W-1:0] diff;
    logic [lfp_pkg::SQ_W-1:0]  sq;
    logic [lfp_pkg::SSE_W:0]   sum;
    logic [lfp_pkg::SSE_W-1:0] sse;
    logic [lfp_pkg::N_W-1:0]   n_raw;
    logic [lfp_pkg::N_W-1:0]   n_eff;
    logic [lfp_pkg::N_W-1:0]   pos_inc;
    logic                      last;

    always_comb
    begin
        diff = (pixel_a > pixel_b) ? (pixel_a - pixel_b) : (pixel_b - pixel_a);
        sq   = lfp_pkg::SQ_W'(diff) * lfp_pkg::SQ_W'(diff);
        sum  = {1'b0, acc_reg} + (lfp_pkg::SSE_W + 1)'(sq);
        // saturate on carry out
        sse  = sum[lfp_pkg::SSE_W] ? '1 : sum[lfp_pkg::SSE_W-1:0];

        n_raw = lfp_pkg::N_W'(ppf);
        if (n_raw == '0)
        begin
            n_eff = lfp_pkg::N_W'(1);
        end
        else if (n_raw > MAX_N)
        begin
            n_eff = MAX_N;
        end
        else
        begin
            n_eff = n_raw;
        end

        // >= so that a frame size lowered mid-frame still closes the frame
        pos_inc = lfp_pkg::N_W'(pos_reg) + lfp_pkg::N_W'(1);
        last    = (pos_inc >= n_eff);

        acc_next = acc_reg;
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        if (take)
        begin
            if (last)
            begin
                acc_next = '0;
                pos_next = '0;
                cnt_next = cnt_reg + lfp_pkg::IDX_W'(1);
            end
            else
            begin
                acc_next = sse;
                pos_next = pos_inc[POS_W-1:0];
            end
        end

        frm.done  = take && last;
        frm.sse   = sse;
        frm.n     = n_eff;
        frm.index = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            pos_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[sv/lfp_seq.sv]
`default_nettype none

module lfp_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire lfp_pkg::lfp_frame_t         frm,
    output logic                             ready,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [lfp_pkg::IDX_W-1:0]        frame_index,
    output logic [lfp_pkg::SSE_W-1:0]        squared_error_sum,
    output logic [lfp_pkg::PSNR_W-1:0]       psnr_db,
    output logic                             frames_identical
);

    lfp_pkg::lfp_state_t state_reg;
    lfp_pkg::lfp_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic [lfp_pkg::SSE_W-1:0]  sse_reg,   sse_next;
    logic [lfp_pkg::N_W-1:0]    n_reg,     n_next;
    logic [lfp_pkg::IDX_W-1:0]  fidx_reg,  fidx_next;
    logic [lfp_pkg::X_W-1:0]    x_reg,     x_next;
    logic [lfp_pkg::E_W-1:0]    e_reg,     e_next;
    logic [lfp_pkg::MUL_W-1:0]  m_reg,     m_next;
    logic [lfp_pkg::FRAC_W-1:0] frac_reg,  frac_next;
    logic [lfp_pkg::BIT_W-1:0]  bit_reg,   bit_next;
    logic                       second_reg, second_next;
    logic [lfp_pkg::L_W-1:0]    lp_reg,    lp_next;
    logic [lfp_pkg::L_W-1:0]    d_reg,     d_next;
    logic [lfp_pkg::PSNR_W-1:0] psnr_reg,  psnr_next;
    logic                       ident_reg, ident_next;

    logic [lfp_pkg::IDX_W-1:0]  o_idx_reg,   o_idx_next;
    logic [lfp_pkg::SSE_W-1:0]  o_sse_reg,   o_sse_next;
    logic [lfp_pkg::PSNR_W-1:0] o_psnr_reg,  o_psnr_next;
    logic                       o_ident_reg, o_ident_next;

    logic [lfp_pkg::MUL_W-1:0]  mul_a;
    logic [lfp_pkg::MUL_W-1:0]  mul_b;
    logic [lfp_pkg::PROD_W-1:0] prod;

    logic [lfp_pkg::MUL_W:0]    sq_t;
    logic                       sq_bit;
    logic [lfp_pkg::MUL_W-1:0]  m_new;
    logic [lfp_pkg::L_W-1:0]    l_now;
    logic [lfp_pkg::PROD_W-1:0] rnd;
    logic [lfp_pkg::PROD_W-41:0] v;

    lfp_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        sse_next       = sse_reg;
        n_next         = n_reg;
        fidx_next      = fidx_reg;
        x_next         = x_reg;
        e_next         = e_reg;
        m_next         = m_reg;
        frac_next      = frac_reg;
        bit_next       = bit_reg;
        second_next    = second_reg;
        lp_next        = lp_reg;
        d_next         = d_reg;
        psnr_next      = psnr_reg;
        ident_next     = ident_reg;
        o_idx_next     = o_idx_reg;
        o_sse_next     = o_sse_reg;
        o_psnr_next    = o_psnr_reg;
        o_ident_next   = o_ident_reg;
        mul_a          = m_reg;
        mul_b          = m_reg;

        // Q1.31 squared is Q2.62; keep Q2.31
        sq_t   = prod[lfp_pkg::PROD_W-1:lfp_pkg::MUL_W-1];
        sq_bit = sq_t[lfp_pkg::MUL_W];
        m_new  = sq_bit ? sq_t[lfp_pkg::MUL_W:1] : sq_t[lfp_pkg::MUL_W-1:0];
        l_now  = {e_reg, frac_reg};
        rnd    = prod + lfp_pkg::ROUND_HALF;
        v      = rnd[lfp_pkg::PROD_W-1:40];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            lfp_pkg::ST_IDLE:
            begin
                if (frm.done)
                begin
                    sse_next    = frm.sse;
                    n_next      = frm.n;
                    fidx_next   = frm.index;
                    second_next = 1'b0;
                    if (frm.sse == '0)
                    begin
                        psnr_next  = lfp_pkg::PSNR_MAX;
                        ident_next = 1'b1;
                        state_next = lfp_pkg::ST_HOLD;
                    end
                    else
                    begin
                        ident_next = 1'b0;
                        state_next = lfp_pkg::ST_MULP;
                    end
                end
            end

            lfp_pkg::ST_MULP:
            begin
                mul_a      = lfp_pkg::MUL_W'(n_reg);
                mul_b      = lfp_pkg::MUL_W'(lfp_pkg::LUMA_PEAK_SQ);
                state_next = lfp_pkg::ST_LOADP;
            end

            lfp_pkg::ST_LOADP:
            begin
                x_next     = prod[lfp_pkg::X_W-1:0];
                e_next     = lfp_pkg::E_W'(lfp_pkg::X_W - 1);
                state_next = lfp_pkg::ST_NORM;
            end

            lfp_pkg::ST_NORM:
            begin
                // leading-one search: byte steps first, then single bits
                if (x_reg[lfp_pkg::X_W-1 -: 8] == '0)
                begin
                    x_next = x_reg << 8;
                    e_next = e_reg - lfp_pkg::E_W'(8);
                end
                else if (!x_reg[lfp_pkg::X_W-1])
                begin
                    x_next = x_reg << 1;
                    e_next = e_reg - lfp_pkg::E_W'(1);
                end
                else
                begin
                    m_next     = x_reg[lfp_pkg::X_W-1 -: lfp_pkg::MUL_W];
                    frac_next  = '0;
                    bit_next   = lfp_pkg::BIT_W'(lfp_pkg::FRAC_W - 1);
                    state_next = lfp_pkg::ST_SQ_START;
                end
            end

            lfp_pkg::ST_SQ_START:
            begin
                state_next = lfp_pkg::ST_SQ_RUN;
            end

            lfp_pkg::ST_SQ_RUN:
            begin
                m_next             = m_new;
                mul_a              = m_new;
                mul_b              = m_new;
                frac_next[bit_reg] = sq_bit;
                l_now              = {e_reg, frac_next};
                if (bit_reg == '0)
                begin
                    if (!second_reg)
                    begin
                        lp_next     = l_now;
                        x_next      = lfp_pkg::X_W'(sse_reg);
                        e_next      = lfp_pkg::E_W'(lfp_pkg::X_W - 1);
                        second_next = 1'b1;
                        state_next  = lfp_pkg::ST_NORM;
                    end
                    else
                    begin
                        d_next     = (lp_reg > l_now) ? (lp_reg - l_now) : '0;
                        state_next = lfp_pkg::ST_SCALE;
                    end
                end
                else
                begin
                    bit_next = bit_reg - lfp_pkg::BIT_W'(1);
                end
            end

            lfp_pkg::ST_SCALE:
            begin
                mul_a      = lfp_pkg::MUL_W'(d_reg);
                mul_b      = lfp_pkg::MUL_W'(lfp_pkg::TEN_LOG10_2_Q24);
                state_next = lfp_pkg::ST_ROUND;
            end

            lfp_pkg::ST_ROUND:
            begin
                if (v > ($bits(v))'(lfp_pkg::PSNR_MAX))
                begin
                    psnr_next = lfp_pkg::PSNR_MAX;
                end
                else
                begin
                    psnr_next = v[lfp_pkg::PSNR_W-1:0];
                end
                state_next = lfp_pkg::ST_HOLD;
            end

            lfp_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_idx_next     = fidx_reg;
                    o_sse_next     = sse_reg;
                    o_psnr_next    = psnr_reg;
                    o_ident_next   = ident_reg;
                    state_next     = lfp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lfp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sse_reg     <= sse_next;
        n_reg       <= n_next;
        fidx_reg    <= fidx_next;
        x_reg       <= x_next;
        e_reg       <= e_next;
        m_reg       <= m_next;
        frac_reg    <= frac_next;
        bit_reg     <= bit_next;
        second_reg  <= second_next;
        lp_reg      <= lp_next;
        d_reg       <= d_next;
        psnr_reg    <= psnr_next;
        ident_reg   <= ident_next;
        o_idx_reg   <= o_idx_next;
        o_sse_reg   <= o_sse_next;
        o_psnr_reg  <= o_psnr_next;
        o_ident_reg <= o_ident_next;
    end

    assign ready             = (state_reg == lfp_pkg::ST_IDLE);
    assign out_valid         = out_valid_reg;
    assign frame_index       = o_idx_reg;
    assign squared_error_sum = o_sse_reg;
    assign psnr_db           = o_psnr_reg;
    assign frames_identical  = o_ident_reg;

endmodule

`default_nettype wire

[sv/luma_frame_psnr_top.sv]
// Luma PSNR meter for 8-bit frames.
// Input channel: pixel_a / pixel_b, one co-located sample pair per transfer
// (in_valid, in_stall). Every pair adds its squared difference to the frame sum.
// Output channel: one result per frame (out_valid, out_stall) with frame_index,
// squared_error_sum, psnr_db (unsigned Q7.8 dB) and frames_identical.
// Config channel: pixels_per_frame written by cfg_valid/cfg_ready; ready is
// always high. 0 counts as 1, values above MAX_PIXELS count as MAX_PIXELS.
// Throughput: one pair per cycle within a frame. After the last pair of a frame
// in_stall stays high while a single shared 32x32 multiplier and a shifter work
// out two base-2 logs (24 squaring steps each, plus a byte/bit leading-one
// search) and the final scaling; a zero frame sum skips this work. out_valid
// rises as that stretch ends.
// The result then sits in an output register; a stalled receiver holds it there
// and the next frame streams in, the block stalling only if a further frame
// finishes before that result has gone.
// Reset clears the frame sum, pixel position, frame counter and output valid,
// and sets pixels_per_frame to 101376.
`default_nettype none

module luma_frame_psnr_top #(
    parameter int MAX_PIXELS = 4194304
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [lfp_pkg::PIX_W-1:0]    pixel_a,
    input  wire logic [lfp_pkg::PIX_W-1:0]    pixel_b,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [lfp_pkg::IDX_W-1:0]         frame_index,
    output logic [lfp_pkg::SSE_W-1:0]         squared_error_sum,
    output logic [lfp_pkg::PSNR_W-1:0]        psnr_db,
    output logic                              frames_identical,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [lfp_pkg::PPF_W-1:0]    pixels_per_frame
);

    logic [lfp_pkg::PPF_W-1:0] ppf_reg;
    logic [lfp_pkg::PPF_W-1:0] ppf_next;
    logic                      seq_ready;
    logic                      take;
    lfp_pkg::lfp_frame_t       frm;

    assign cfg_ready = 1'b1;
    assign ppf_next  = (cfg_valid && cfg_ready) ? pixels_per_frame : ppf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppf_reg <= lfp_pkg::PPF_RESET;
        end
        else
        begin
            ppf_reg <= ppf_next;
        end
    end

    assign in_stall = !seq_ready;
    assign take     = in_valid && seq_ready;

    lfp_accum #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .pixel_a (pixel_a),
        .pixel_b (pixel_b),
        .ppf     (ppf_reg),
        .frm     (frm)
    );

    lfp_seq u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .frm               (frm),
        .ready             (seq_ready),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .frame_index       (frame_index),
        .squared_error_sum (squared_error_sum),
        .psnr_db           (psnr_db),
        .frames_identical  (frames_identical)
    );

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          SETTLE_CYCLES  = 120;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          RANDOM_ITEMS   = 160;
    localparam int          PARTIAL_ITEMS  = 24;
    localparam int          RESET_FRAME    = 101376;
    localparam logic [63:0] PEAK_SQ        = 64'd65025;
    localparam logic [63:0] DB_PER_OCT_Q24 = 64'd50504453;
    localparam logic [63:0] ROUND_Q40      = 64'd1 << 39;
    localparam logic [63:0] PSNR_CEIL      = 64'd32767;
    localparam logic [63:0] SSE_CEIL       = (64'd1 << 38) - 64'd1;
    localparam logic [63:0] FRAME_CAP      = 64'd4194304;

    typedef enum int { PAIR_SAME, PAIR_CLOSE, PAIR_EDGE, PAIR_ANY } pair_mode_t;

    typedef struct {
        logic [lfp_pkg::PIX_W-1:0] a;
        logic [lfp_pkg::PIX_W-1:0] b;
    } luma_pair_t;

    typedef struct {
        logic [lfp_pkg::IDX_W-1:0]  index;
        logic [lfp_pkg::SSE_W-1:0]  sse;
        logic [lfp_pkg::PSNR_W-1:0] psnr;
        logic                       same;
    } frame_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [lfp_pkg::PIX_W-1:0]   pixel_a = '0;
    logic [lfp_pkg::PIX_W-1:0]   pixel_b = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [lfp_pkg::IDX_W-1:0]   frame_index;
    logic [lfp_pkg::SSE_W-1:0]   squared_error_sum;
    logic [lfp_pkg::PSNR_W-1:0]  psnr_db;
    logic                        frames_identical;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [lfp_pkg::PPF_W-1:0]   pixels_per_frame = '0;

    luma_pair_t    pairs_pending[$];
    frame_result_t frame_results_due[$];

    // copy of the block's frame state
    logic [lfp_pkg::PPF_W-1:0]   frame_size_model = lfp_pkg::PPF_W'(RESET_FRAME);
    logic [63:0]                 sse_model = '0;
    logic [63:0]                 position_model = '0;
    logic [lfp_pkg::IDX_W-1:0]   frame_count_model = '0;

    logic in_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_tickets = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    int   mismatch_count = 0;

    luma_frame_psnr_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .pixel_a           (pixel_a),
        .pixel_b           (pixel_b),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .frame_index       (frame_index),
        .squared_error_sum (squared_error_sum),
        .psnr_db           (psnr_db),
        .frames_identical  (frames_identical),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .pixels_per_frame  (pixels_per_frame)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // log2 in Q.24: leading-one position, then fraction bits by repeated squaring
    function automatic logic [63:0] log2_q24(input logic [63:0] x);
        int          lead;
        int          k;
        logic [63:0] m;
        logic [63:0] r;
        lead = 0;
        for (k = 0; k < 64; k++)
        begin
            if (x[k])
                lead = k;
        end
        m = (lead <= 31) ? (x << (31 - lead)) : (x >> (lead - 31));
        r = 64'(lead) << 24;
        for (k = 23; k >= 0; k--)
        begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32))
            begin
                m = m >> 1;
                r[k] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [lfp_pkg::PSNR_W-1:0] frame_psnr_q8(input logic [63:0] n,
                                                                input logic [63:0] sse);
        logic [63:0] lp;
        logic [63:0] ls;
        logic [63:0] d;
        logic [63:0] v;
        lp = log2_q24(PEAK_SQ * n);
        ls = log2_q24(sse);
        d = (lp > ls) ? (lp - ls) : 64'd0;
        v = (d * DB_PER_OCT_Q24 + ROUND_Q40) >> 40;
        if (v > PSNR_CEIL)
            v = PSNR_CEIL;
        return v[lfp_pkg::PSNR_W-1:0];
    endfunction

    // adds one pair to the frame sum; queues a result at the end of a frame
    task automatic accumulate_pair(input logic [lfp_pkg::PIX_W-1:0] a,
                                   input logic [lfp_pkg::PIX_W-1:0] b);
        logic [63:0]   diff;
        logic [63:0]   n;
        frame_result_t res;
        diff = (a > b) ? 64'(a - b) : 64'(b - a);
        n = 64'(frame_size_model);
        if (n == 0)
            n = 1;
        if (n > FRAME_CAP)
            n = FRAME_CAP;
        sse_model = sse_model + diff * diff;
        if (sse_model > SSE_CEIL)
            sse_model = SSE_CEIL;
        if (position_model + 1 < n)
            position_model = position_model + 1;
        else
        begin
            res.index = frame_count_model;
            res.sse   = sse_model[lfp_pkg::SSE_W-1:0];
            res.same  = (sse_model == 0);
            res.psnr  = res.same ? PSNR_CEIL[lfp_pkg::PSNR_W-1:0]
                                 : frame_psnr_q8(n, sse_model);
            frame_results_due.push_back(res);
            sse_model = '0;
            position_model = '0;
            frame_count_model = frame_count_model + 1'b1;
        end
    endtask

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // sender: a stalled transfer is held; idling is decided only between transfers
    always @(negedge clk)
    begin : sender
        luma_pair_t p;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pairs_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                p = pairs_pending.pop_front();
                in_valid <= 1'b1;
                pixel_a  <= p.a;
                pixel_b  <= p.b;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : receiver
        if (hold_served != hold_tickets)
        begin
            hold_served = hold_served + 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin : monitor
        frame_result_t due;
        logic          in_fire;
        logic          out_fire;
        in_fire  = rst_n && in_valid && !in_stall;
        out_fire = rst_n && out_valid && !out_stall;
        in_taken <= in_fire;
        // check before predicting: a result can never leave on the edge its last pair enters
        if (out_fire)
        begin
            if (frame_results_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual index %0d sse %0d",
                         $time, frame_index, squared_error_sum);
                mismatch_count++;
            end
            else
            begin
                due = frame_results_due.pop_front();
                compare_field("frame_index", 64'(due.index), 64'(frame_index));
                compare_field("squared_error_sum", 64'(due.sse), 64'(squared_error_sum));
                compare_field("psnr_db", 64'(due.psnr), 64'(psnr_db));
                compare_field("frames_identical", 64'(due.same), 64'(frames_identical));
            end
        end
        if (in_fire)
            accumulate_pair(pixel_a, pixel_b);
        if (in_fire || out_fire || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("status: fail");
            $finish;
        end
    end

    function automatic luma_pair_t make_pair(input pair_mode_t mode);
        luma_pair_t p;
        p.a = lfp_pkg::PIX_W'($urandom_range(255));
        case (mode)
            PAIR_SAME:  p.b = p.a;
            PAIR_CLOSE: p.b = lfp_pkg::PIX_W'(32'(p.a) + $urandom_range(4) - 2);
            PAIR_EDGE:
            begin
                p.a = $urandom_range(1) ? 8'd255 : 8'd0;
                p.b = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            default:    p.b = lfp_pkg::PIX_W'($urandom_range(255));
        endcase
        return p;
    endfunction

    task automatic queue_pair(input int a, input int b);
        luma_pair_t p;
        p.a = lfp_pkg::PIX_W'(a);
        p.b = lfp_pkg::PIX_W'(b);
        pairs_pending.push_back(p);
    endtask

    task automatic queue_pairs(input pair_mode_t mode, input int count);
        repeat (count)
            pairs_pending.push_back(make_pair(mode));
    endtask

    // transfers drained, results in, and the log pipeline given time to finish
    task automatic wait_until_idle;
        while (pairs_pending.size() != 0 || in_valid || frame_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_size(input logic [lfp_pkg::PPF_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        pixels_per_frame <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        frame_size_model = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int         phase;
        int         items;
        int         size;
        int         effective;
        int         pick;
        pair_mode_t mode;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 16;
        recv_idle_pct = 81;

        // part of a frame at the reset frame size; after the next size write the next pair closes it
        @(posedge clk);
        queue_pairs(PAIR_ANY, PARTIAL_ITEMS);
        wait_until_idle();

        // single-pixel frames: identical, extreme differences
        write_frame_size(1);
        queue_pair(0, 0);
        queue_pair(255, 0);
        queue_pair(0, 255);
        queue_pair(255, 255);
        queue_pair(128, 127);
        wait_until_idle();

        // zero frame size behaves as one
        write_frame_size(0);
        queue_pair(0, 0);
        queue_pair(255, 0);
        queue_pair(170, 85);
        queue_pair(85, 170);
        wait_until_idle();

        write_frame_size(4);
        queue_pair(0, 255);
        queue_pair(255, 0);
        queue_pair(1, 0);
        queue_pair(0, 1);
        wait_until_idle();

        write_frame_size(2);
        queue_pair(255, 255);
        queue_pair(0, 0);
        wait_until_idle();

        // oversized frame, then shrunk below the current position mid-frame
        write_frame_size({lfp_pkg::PPF_W{1'b1}});
        queue_pair(3, 3);
        queue_pair(200, 17);
        queue_pair(0, 255);
        queue_pair(90, 91);
        queue_pair(255, 254);
        queue_pair(7, 7);
        wait_until_idle();
        write_frame_size(3);
        queue_pair(42, 40);
        wait_until_idle();

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 16;
                    recv_idle_pct = 81;
                end
                1:
                begin
                    send_idle_pct = 81;
                    recv_idle_pct = 16;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // receiver holds off while frames keep finishing: block must back up
                    write_frame_size(1);
                    @(posedge clk);
                    queue_pairs(PAIR_ANY, 40);
                    hold_tickets = hold_tickets + 1;
                    wait_until_idle();
                end
            endcase

            items = 0;
            while (items < RANDOM_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    size = 0;
                else if (pick < 20)
                    size = 1;
                else if (pick < 80)
                    size = $urandom_range(24, 2);
                else
                    size = $urandom_range(120, 25);
                effective = (size == 0) ? 1 : size;
                write_frame_size(lfp_pkg::PPF_W'(size));
                @(posedge clk);
                repeat ($urandom_range(4, 1))
                begin
                    pick = $urandom_range(99);
                    if (pick < 15)
                        mode = PAIR_SAME;
                    else if (pick < 35)
                        mode = PAIR_CLOSE;
                    else if (pick < 50)
                        mode = PAIR_EDGE;
                    else
                        mode = PAIR_ANY;
                    queue_pairs(mode, effective);
                    items = items + effective;
                end
                wait_until_idle();
            end
        end

        wait_until_idle();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
